@@ hdl/srtf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared types, codes and defaults for the shortest-remaining-time scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

    // field widths of the channel payloads
    localparam int SLOT_W  = 4;
    localparam int BURST_W = 16;
    localparam int OUT_W   = 16;

    // defaults for the top-level parameters
    localparam int DEF_SLOTS     = 16;
    localparam int DEF_TIME_BITS = 16;

    // operation codes carried in func
    localparam logic FUNC_ARRIVE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_OCCUPIED = 2'd1;
    localparam logic [1:0] STAT_ZERO     = 2'd2;

    // classified command passed from the front end to the execution unit
    typedef struct packed {
        logic               is_tick;
        logic               slot_ok;
        logic               zero_burst;
        logic [SLOT_W-1:0]  slot;
        logic [BURST_W-1:0] burst;
    } cmd_t;

endpackage

@@ hdl/srtf_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_cmd_if / srtf_res_if
// Valid/ready channels for scheduler commands and scheduler results.
// ----------------------------------------------------------------------------
interface srtf_cmd_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [3:0]  slot;
    logic [15:0] burst_time;

    modport source (output valid, output func, output slot, output burst_time, input ready);
    modport sink   (input valid, input func, input slot, input burst_time, output ready);
endinterface

interface srtf_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  ran_slot;
    logic        cpu_idle;
    logic        finished;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic [15:0] response;
    logic [15:0] current_time;
    logic [15:0] idle_total;

    modport source (
        output valid, output status, output ran_slot, output cpu_idle, output finished,
        output turnaround, output waiting, output response, output current_time,
        output idle_total, input ready
    );
    modport sink (
        input valid, input status, input ran_slot, input cpu_idle, input finished,
        input turnaround, input waiting, input response, input current_time,
        input idle_total, output ready
    );
endinterface

@@ hdl/srtf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srtf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hdl/srtf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_front
// Accepts command transactions, classifies them and buffers them in a
// two-entry queue ahead of the execution unit.
// ----------------------------------------------------------------------------
module srtf_front #(
    parameter int SLOTS = srtf_pkg::DEF_SLOTS
) (
    input  logic            clk,
    input  logic            rst_n,
    srtf_cmd_if.sink        cmd,
    output logic            q_vld,
    output srtf_pkg::cmd_t  q_head,
    input  logic            q_pop
);
    import srtf_pkg::*;

    localparam int QD = 2;

    cmd_t       q_mem_reg [QD];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;
    cmd_t       cls;

    // classify the incoming command
    always_comb
    begin
        cls.is_tick    = (cmd.func == FUNC_TICK);
        cls.slot_ok    = (int'(cmd.slot) < SLOTS);
        cls.zero_burst = (cmd.burst_time == '0);
        cls.slot       = cmd.slot;
        cls.burst      = cmd.burst_time;
    end

    // queue control
    assign cmd.ready = (cnt_reg != 2'(QD));
    assign push      = cmd.valid && cmd.ready;
    assign q_vld     = (cnt_reg != 2'd0);
    assign pop       = q_pop && q_vld;
    assign q_head    = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

@@ hdl/srtf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_back
// Execution unit: loads arrivals into the slot table, walks the table one
// slot per cycle to pick the shortest remaining time, runs it and reports.
// ----------------------------------------------------------------------------
module srtf_back #(
    parameter int SLOTS     = srtf_pkg::DEF_SLOTS,
    parameter int TIME_BITS = srtf_pkg::DEF_TIME_BITS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_vld,
    input  srtf_pkg::cmd_t  q_head,
    output logic            q_pop,
    srtf_res_if.source      res
);
    import srtf_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TB    = TIME_BITS;
    localparam int ROW_W = 4 * TB;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [TB-1:0]    TMAX     = {TB{1'b1}};

    function automatic logic [TB-1:0] sat_inc(input logic [TB-1:0] v);
        return (v == TMAX) ? v : v + 1'b1;
    endfunction

    // control state
    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             best_vld_reg, best_vld_next;
    logic [SLOTS-1:0] occ_reg, occ_next;
    logic [SLOTS-1:0] started_reg, started_next;
    logic [TB-1:0]    time_reg, time_next;
    logic [TB-1:0]    idle_reg, idle_next;
    logic             res_vld_reg, res_vld_next;

    // datapath registers
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [TB-1:0]    best_arr_reg, best_arr_next;
    logic [TB-1:0]    best_burst_reg, best_burst_next;
    logic [TB-1:0]    best_rem_reg, best_rem_next;
    logic [TB-1:0]    best_fs_reg, best_fs_next;
    logic [TB-1:0]    fs_reg, fs_next;
    logic             done_reg, done_next;
    logic [1:0]       o_status_reg, o_status_next;
    logic [3:0]       o_ran_reg, o_ran_next;
    logic             o_idle_reg, o_idle_next;
    logic             o_fin_reg, o_fin_next;
    logic [TB-1:0]    o_tat_reg, o_tat_next;
    logic [TB-1:0]    o_wt_reg, o_wt_next;
    logic [TB-1:0]    o_rt_reg, o_rt_next;
    logic [TB-1:0]    o_time_reg, o_time_next;
    logic [TB-1:0]    o_itot_reg, o_itot_next;

    // slot table port signals
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ROW_W-1:0] wr_data;
    logic [IDX_W-1:0] rd_addr;
    logic [ROW_W-1:0] rd_data;

    // helpers
    logic [TB-1:0]    cand_arr, cand_burst, cand_rem, cand_fs;
    logic             cand_better;
    logic [IDX_W-1:0] arr_idx;
    logic [TB-1:0]    bsat;
    logic [TB-1:0]    fs_use;
    logic [TB-1:0]    rem_new;
    logic [TB-1:0]    tat;

    // slot table: {arrival, burst, remaining, first start} per slot
    srtf_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SLOTS)
    ) u_tbl (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // unpack the row read back and compare against the current best
    assign cand_arr   = rd_data[4*TB-1:3*TB];
    assign cand_burst = rd_data[3*TB-1:2*TB];
    assign cand_rem   = rd_data[2*TB-1:TB];
    assign cand_fs    = rd_data[TB-1:0];
    assign cand_better = rd_vld_reg && occ_reg[rd_idx_reg] &&
                         (!best_vld_reg || (cand_rem < best_rem_reg) ||
                          ((cand_rem == best_rem_reg) && (cand_arr < best_arr_reg)));

    // arrival decode
    assign arr_idx = IDX_W'(q_head.slot);
    assign bsat    = (33'(q_head.burst) > 33'(TMAX)) ? TMAX : TB'(q_head.burst);

    // run step for the picked slot
    assign fs_use  = started_reg[best_idx_reg] ? best_fs_reg : time_reg;
    assign rem_new = (best_rem_reg != '0) ? best_rem_reg - 1'b1 : best_rem_reg;
    assign tat     = time_reg - best_arr_reg;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        best_vld_next   = best_vld_reg;
        occ_next        = occ_reg;
        started_next    = started_reg;
        time_next       = time_reg;
        idle_next       = idle_reg;
        res_vld_next    = res_vld_reg && !res.ready;
        best_idx_next   = best_idx_reg;
        best_arr_next   = best_arr_reg;
        best_burst_next = best_burst_reg;
        best_rem_next   = best_rem_reg;
        best_fs_next    = best_fs_reg;
        fs_next         = fs_reg;
        done_next       = done_reg;
        o_status_next   = o_status_reg;
        o_ran_next      = o_ran_reg;
        o_idle_next     = o_idle_reg;
        o_fin_next      = o_fin_reg;
        o_tat_next      = o_tat_reg;
        o_wt_next       = o_wt_reg;
        o_rt_next       = o_rt_reg;
        o_time_next     = o_time_reg;
        o_itot_next     = o_itot_reg;
        q_pop           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = best_idx_reg;
        wr_data         = {best_arr_reg, best_burst_reg, rem_new, fs_use};
        rd_addr         = idx_reg;

        // running minimum over the rows coming back from the table
        if (cand_better)
        begin
            best_vld_next   = 1'b1;
            best_idx_next   = rd_idx_reg;
            best_arr_next   = cand_arr;
            best_burst_next = cand_burst;
            best_rem_next   = cand_rem;
            best_fs_next    = cand_fs;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_vld && !res_vld_reg)
                begin
                    q_pop         = 1'b1;
                    o_status_next = STAT_OK;
                    o_ran_next    = 4'd0;
                    o_idle_next   = 1'b0;
                    o_fin_next    = 1'b0;
                    o_tat_next    = '0;
                    o_wt_next     = '0;
                    o_rt_next     = '0;
                    o_time_next   = time_reg;
                    o_itot_next   = idle_reg;
                    if (!q_head.is_tick)
                    begin
                        // arrival: refuse or load the slot
                        res_vld_next = 1'b1;
                        if (!q_head.slot_ok || occ_reg[arr_idx])
                        begin
                            o_status_next = STAT_OCCUPIED;
                        end
                        else if (q_head.zero_burst)
                        begin
                            o_status_next = STAT_ZERO;
                        end
                        else
                        begin
                            wr_en                 = 1'b1;
                            wr_addr               = arr_idx;
                            wr_data               = {time_reg, bsat, bsat, {TB{1'b0}}};
                            occ_next[arr_idx]     = 1'b1;
                            started_next[arr_idx] = 1'b0;
                        end
                    end
                    else if (occ_reg == '0)
                    begin
                        // idle tick
                        res_vld_next = 1'b1;
                        time_next    = sat_inc(time_reg);
                        idle_next    = sat_inc(idle_reg);
                        o_idle_next  = 1'b1;
                        o_time_next  = sat_inc(time_reg);
                        o_itot_next  = sat_inc(idle_reg);
                    end
                    else
                    begin
                        state_next    = S_SCAN;
                        idx_next      = '0;
                        best_vld_next = 1'b0;
                    end
                end
            end

            S_SCAN:
            begin
                // issue one slot read per cycle
                rd_vld_next = 1'b1;
                rd_idx_next = idx_reg;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_DRAIN:
            begin
                state_next = S_UPDATE;
            end

            S_UPDATE:
            begin
                // run the picked slot for one unit
                time_next = sat_inc(time_reg);
                fs_next   = fs_use;
                if (rem_new == '0)
                begin
                    done_next                  = 1'b1;
                    occ_next[best_idx_reg]     = 1'b0;
                    started_next[best_idx_reg] = 1'b0;
                end
                else
                begin
                    done_next                  = 1'b0;
                    wr_en                      = 1'b1;
                    started_next[best_idx_reg] = 1'b1;
                end
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                // build the tick result
                res_vld_next  = 1'b1;
                o_status_next = STAT_OK;
                o_ran_next    = 4'(best_idx_reg);
                o_idle_next   = 1'b0;
                o_fin_next    = done_reg;
                o_tat_next    = '0;
                o_wt_next     = '0;
                o_rt_next     = '0;
                o_time_next   = time_reg;
                o_itot_next   = idle_reg;
                if (done_reg)
                begin
                    o_tat_next = tat;
                    o_wt_next  = (tat > best_burst_reg) ? tat - best_burst_reg : '0;
                    o_rt_next  = fs_reg - best_arr_reg;
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            rd_idx_reg   <= '0;
            best_vld_reg <= 1'b0;
            occ_reg      <= '0;
            started_reg  <= '0;
            time_reg     <= '0;
            idle_reg     <= '0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            rd_vld_reg   <= rd_vld_next;
            rd_idx_reg   <= rd_idx_next;
            best_vld_reg <= best_vld_next;
            occ_reg      <= occ_next;
            started_reg  <= started_next;
            time_reg     <= time_next;
            idle_reg     <= idle_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        best_idx_reg   <= best_idx_next;
        best_arr_reg   <= best_arr_next;
        best_burst_reg <= best_burst_next;
        best_rem_reg   <= best_rem_next;
        best_fs_reg    <= best_fs_next;
        fs_reg         <= fs_next;
        done_reg       <= done_next;
        o_status_reg   <= o_status_next;
        o_ran_reg      <= o_ran_next;
        o_idle_reg     <= o_idle_next;
        o_fin_reg      <= o_fin_next;
        o_tat_reg      <= o_tat_next;
        o_wt_reg       <= o_wt_next;
        o_rt_reg       <= o_rt_next;
        o_time_reg     <= o_time_next;
        o_itot_reg     <= o_itot_next;
    end

    // result channel
    assign res.valid        = res_vld_reg;
    assign res.status       = o_status_reg;
    assign res.ran_slot     = o_ran_reg;
    assign res.cpu_idle     = o_idle_reg;
    assign res.finished     = o_fin_reg;
    assign res.turnaround   = OUT_W'(o_tat_reg);
    assign res.waiting      = OUT_W'(o_wt_reg);
    assign res.response     = OUT_W'(o_rt_reg);
    assign res.current_time = OUT_W'(o_time_reg);
    assign res.idle_total   = OUT_W'(o_itot_reg);

endmodule

@@ hdl/srtf_tick_scheduler.sv @@
`timescale 1ns / 1ps
// An arrive or an idle tick registers its result on acceptance in the idle state; a tick that finds
// an occupied slot gives its result after the scan, drain, update and finish states.
// A tick is paced by the walk over the slot table, one slot per cycle through its single
// read port; the execution unit takes a new command only in idle, once the last result is taken.
// A two-entry command queue keeps accepting while the execution unit is busy, until it is full.
// Reset (rst_n, async, active low) empties every slot and zeroes time and idle counters.
// ----------------------------------------------------------------------------
// srtf_tick_scheduler
// Preemptive shortest-remaining-time scheduler over a table of process slots.
// ----------------------------------------------------------------------------
module srtf_tick_scheduler #(
    parameter int SLOTS     = srtf_pkg::DEF_SLOTS,
    parameter int TIME_BITS = srtf_pkg::DEF_TIME_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    srtf_cmd_if.sink    cmd,
    srtf_res_if.source  res
);
    import srtf_pkg::*;

    logic q_vld;
    cmd_t q_head;
    logic q_pop;

    // command intake and queue
    srtf_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .q_vld  (q_vld),
        .q_head (q_head),
        .q_pop  (q_pop)
    );

    // scheduling and bookkeeping
    srtf_back #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_vld  (q_vld),
        .q_head (q_head),
        .q_pop  (q_pop),
        .res    (res)
    );

endmodule

@@ hdl/srtf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_checker
// Port-level checks on the result channel of the scheduler.
// ----------------------------------------------------------------------------
module srtf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  status,
    input logic [3:0]  ran_slot,
    input logic        cpu_idle,
    input logic        finished,
    input logic [15:0] turnaround,
    input logic [15:0] current_time,
    input logic [15:0] idle_total
);
    import srtf_pkg::*;

    // a stalled result keeps its time stamp
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(current_time))
        else $error("stalled result changed");

    // refused arrivals carry no tick information
    a_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status != STAT_OK) |-> !cpu_idle && !finished && (turnaround == 16'd0))
        else $error("refused arrival reports tick data");

    // an idle tick runs nothing
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && cpu_idle |-> !finished && (ran_slot == 4'd0) && (status == STAT_OK))
        else $error("idle tick reports a run");

    // idle ticks never outnumber elapsed time
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (idle_total <= current_time))
        else $error("idle count exceeds time");

endmodule

bind srtf_tick_scheduler srtf_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .status       (res.status),
    .ran_slot     (res.ran_slot),
    .cpu_idle     (res.cpu_idle),
    .finished     (res.finished),
    .turnaround   (res.turnaround),
    .current_time (res.current_time),
    .idle_total   (res.idle_total)
);
